>>> rtl/lsts_pkg.sv
// Shared types and constants for the loop-seam triangular smoother.
// Used by the front end, the job queue, the engine and the top level.
// No dependencies.
package lsts_pkg;

  localparam int HALF_LENGTH_DEF = 32;
  localparam int HALF_MAX        = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int DATA_W  = 16;
  localparam int POS_W   = 6;
  localparam int HW_W    = 5;   // half-width of the window, up to HALF_MAX-1
  localparam int K_W     = 6;   // tap counter, up to 2*(HALF_MAX-1)
  localparam int WT_W    = 6;   // tap weight, up to HALF_MAX
  localparam int DEN_W   = 11;  // (w+1)^2, up to HALF_MAX^2
  localparam int D_W     = 12;  // divisor 2*(w+1)^2
  localparam int N_W     = 28;  // biased dividend, below 2^16 * divisor
  localparam int ACC_W   = 27;  // signed weighted sum
  localparam int PROD_W  = 23;  // 16-bit sample times 7-bit signed weight
  localparam int STEP_W  = 4;   // divider step counter, one quotient bit a step

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [HW_W-1:0]  half_w;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  typedef enum logic {
    FE_LOAD,
    FE_ISSUE
  } front_state_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_MAC,
    ENG_DRAIN,
    ENG_DIV
  } eng_state_t;

endpackage

>>> rtl/lsts_queue.sv
// Short job queue between the front end and the smoothing engine.
// Depends on lsts_pkg for the job type.
module lsts_queue #(
  parameter int DEPTH = lsts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lsts_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output lsts_pkg::job_t pop_data,
  output logic           empty
);
  import lsts_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/lsts_front.sv
// Front end: takes samples into the window store and, once a window is
// complete, issues one smoothing job per position into the job queue.
// Depends on lsts_pkg.
module lsts_front #(
  parameter int HALF_LENGTH = lsts_pkg::HALF_LENGTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [lsts_pkg::DATA_W-1:0] sample_in,
  output lsts_pkg::mem_wr_t           wr,
  output logic                        push,
  output lsts_pkg::job_t              push_data,
  input  logic                        q_full,
  output logic                        issuing
);
  import lsts_pkg::*;

  localparam int TOTAL = 2 * HALF_LENGTH;
  localparam int AW    = $clog2(TOTAL);

  front_state_t  state;
  front_state_t  state_next;
  logic [AW-1:0] count;
  logic [AW-1:0] idx;
  logic [AW-1:0] mirror;
  logic          accept;

  assign accept  = start && !busy;
  assign issuing = (state == FE_ISSUE);
  assign mirror  = AW'(TOTAL - 1) - idx;

  assign wr.en   = accept;
  assign wr.addr = POS_W'(count);
  assign wr.data = sample_in;

  assign push_data.pos    = POS_W'(idx);
  assign push_data.half_w = HW_W'((idx < mirror) ? idx : mirror);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_LOAD;
      count <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= (count == AW'(TOTAL - 1)) ? '0 : count + 1'b1;
      end
      if (accept && count == AW'(TOTAL - 1)) begin
        idx <= '0;
      end else if (push) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    unique case (state)
      FE_LOAD: begin
        if (accept && count == AW'(TOTAL - 1)) begin
          state_next = FE_ISSUE;
        end
      end
      FE_ISSUE: begin
        push = !q_full;
        if (!q_full && idx == AW'(TOTAL - 1)) begin
          state_next = FE_LOAD;
        end
      end
      default: state_next = FE_LOAD;
    endcase
  end

endmodule

>>> rtl/lsts_engine.sv
// Smoothing engine: holds the window store, runs the triangular-weighted
// sum for one job through a shared multiplier, then a bit-serial divider.
// Depends on lsts_pkg.
module lsts_engine #(
  parameter int HALF_LENGTH = lsts_pkg::HALF_LENGTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lsts_pkg::mem_wr_t           wr,
  input  logic                        job_valid,
  input  lsts_pkg::job_t              job,
  output logic                        pop,
  output logic                        active,
  output logic                        strobe,
  output logic [lsts_pkg::DATA_W-1:0] sample_out,
  output logic [lsts_pkg::POS_W-1:0]  position,
  output logic                        last_of_block
);
  import lsts_pkg::*;

  localparam int TOTAL = 2 * HALF_LENGTH;
  localparam int AW    = $clog2(TOTAL);

  logic [DATA_W-1:0] mem [TOTAL];

  eng_state_t               state;
  eng_state_t               state_next;
  logic [AW-1:0]            pos;
  logic [HW_W-1:0]          w;
  logic [K_W-1:0]           k;
  logic [DEN_W-1:0]         den;
  logic signed [ACC_W-1:0]  acc;
  logic                     rd_vld;
  logic [WT_W-1:0]          wt1;
  logic signed [DATA_W-1:0] rdata;
  logic                     prod_vld;
  logic signed [PROD_W-1:0] prod;
  logic [D_W-1:0]           rem;
  logic [DATA_W-1:0]        nlow;
  logic [DATA_W-1:0]        quo;
  logic [STEP_W-1:0]        step;

  logic                     issue;
  logic                     div_load;
  logic                     div_run;
  logic                     emit;
  logic                     mac_last;
  logic [AW-1:0]            rd_addr;
  logic [WT_W-1:0]          weight;
  logic [DEN_W-1:0]         den_calc;
  logic [N_W+1:0]           num_full;
  logic [N_W-1:0]           num;
  logic [D_W-1:0]           dvs;
  logic [D_W:0]             rem_sh;
  logic                     ge;
  logic [D_W-1:0]           rem_next;
  logic [DATA_W-1:0]        quo_fin;

  assign active   = (state != ENG_IDLE);
  assign mac_last = (k == {w, 1'b0});
  assign rd_addr  = AW'(7'(pos) + 7'(k) - 7'(w));
  assign weight   = (k <= K_W'(w)) ? WT_W'(k + 1'b1)
                                   : WT_W'(7'({w, 1'b1}) - 7'(k));
  assign den_calc = DEN_W'((12'(job.half_w) + 12'd1) * (12'(job.half_w) + 12'd1));

  // Dividend biased by 2^15 divisors so that the floor quotient is never
  // negative; flipping the top quotient bit removes the bias again.
  assign num_full = {{(N_W + 1 - ACC_W){acc[ACC_W-1]}}, acc, 1'b0}
                  + (N_W + 2)'(den) + ((N_W + 2)'(den) << 16);
  assign num      = num_full[N_W-1:0];

  assign dvs      = {den, 1'b0};
  assign rem_sh   = {rem, nlow[DATA_W-1]};
  assign ge       = (rem_sh >= {1'b0, dvs});
  assign rem_next = ge ? D_W'(rem_sh - {1'b0, dvs}) : D_W'(rem_sh);
  assign quo_fin  = {quo[DATA_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    rdata <= signed'(mem[rd_addr]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ENG_IDLE;
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= issue;
      prod_vld <= rd_vld;
      strobe   <= emit;
    end
  end

  always_ff @(posedge clk) begin
    wt1  <= weight;
    prod <= rdata * signed'({1'b0, wt1});
    if (pop) begin
      pos <= job.pos[AW-1:0];
      w   <= job.half_w;
      k   <= '0;
      den <= den_calc;
      acc <= '0;
    end else begin
      if (issue) begin
        k <= k + 1'b1;
      end
      if (prod_vld) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (div_load) begin
      rem  <= num[N_W-1:DATA_W];
      nlow <= num[DATA_W-1:0];
      step <= '0;
    end else if (div_run) begin
      rem  <= rem_next;
      nlow <= {nlow[DATA_W-2:0], 1'b0};
      quo  <= quo_fin;
      step <= step + 1'b1;
    end
    if (emit) begin
      sample_out    <= {~quo_fin[DATA_W-1], quo_fin[DATA_W-2:0]};
      position      <= POS_W'(pos);
      last_of_block <= (pos == AW'(TOTAL - 1));
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    issue      = 1'b0;
    div_load   = 1'b0;
    div_run    = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ENG_IDLE: begin
        if (job_valid) begin
          pop        = 1'b1;
          state_next = ENG_MAC;
        end
      end
      ENG_MAC: begin
        issue = 1'b1;
        if (mac_last) begin
          state_next = ENG_DRAIN;
        end
      end
      ENG_DRAIN: begin
        if (!rd_vld && !prod_vld) begin
          div_load   = 1'b1;
          state_next = ENG_DIV;
        end
      end
      ENG_DIV: begin
        div_run = 1'b1;
        if (step == '1) begin
          emit       = 1'b1;
          state_next = ENG_IDLE;
        end
      end
      default: state_next = ENG_IDLE;
    endcase
  end

endmodule

>>> rtl/loop_seam_triangular_smoother.sv
// Top level of the loop-seam triangular smoother.
// Depends on lsts_pkg, lsts_front, lsts_queue and lsts_engine.

// Samples are taken one per cycle while busy is low, 2*HALF_LENGTH to a window
// (clip head, then clip tail). The transaction that completes the window raises
// busy; the block then emits 2*HALF_LENGTH results in position order, one strobe
// cycle each, and the receiver must take each result in the cycle it appears.
// Each result at half-width w is a multiply-accumulate over 2w+1 taps on the
// single shared multiplier, a drain of the read and multiply pipeline, and the
// one-bit-a-step divider that forms the 16-bit quotient. Busy falls in the
// cycle the last result is strobed.
module loop_seam_triangular_smoother #(
  parameter int HALF_LENGTH = lsts_pkg::HALF_LENGTH_DEF,
  parameter int QUEUE_DEPTH = lsts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [lsts_pkg::DATA_W-1:0] sample_in,
  output logic                        strobe,
  output logic [lsts_pkg::DATA_W-1:0] sample_out,
  output logic [lsts_pkg::POS_W-1:0]  position,
  output logic                        last_of_block
);
  import lsts_pkg::*;

  mem_wr_t wr;
  job_t    q_in;
  job_t    q_out;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  logic    issuing;
  logic    eng_active;

  assign busy = issuing || !q_empty || eng_active;

  lsts_front #(
    .HALF_LENGTH(HALF_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .sample_in (sample_in),
    .wr        (wr),
    .push      (q_push),
    .push_data (q_in),
    .q_full    (q_full),
    .issuing   (issuing)
  );

  lsts_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  lsts_engine #(
    .HALF_LENGTH(HALF_LENGTH)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .wr            (wr),
    .job_valid     (!q_empty),
    .job           (q_out),
    .pop           (q_pop),
    .active        (eng_active),
    .strobe        (strobe),
    .sample_out    (sample_out),
    .position      (position),
    .last_of_block (last_of_block)
  );

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("engine took a job from an empty queue");

  a_busy_mid_block: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_of_block) |-> busy)
    else $error("block went idle before the last result of the window");

  a_no_load_while_issuing: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !issuing && !eng_active)
    else $error("window store written while jobs are in flight");
`endif

endmodule
